// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console character writer
// Field widths, character codes, register indexes and the queue entry format
// used by the front, the queue and the back of the writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CHAR_W    = 8;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;

  localparam logic [CHAR_W-1:0] CODE_BS = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR = 8'd13;
  localparam logic [CHAR_W-1:0] BLANK   = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd1;

  localparam logic [COL_W-1:0] CFG_COLS_RESET = 7'd80;
  localparam logic [ROW_W-1:0] CFG_ROWS_RESET = 5'd25;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    K_READ,
    K_BS,
    K_LF,
    K_CR,
    K_PUT
  } kind_t;

  // One classified transaction waiting for the back end.
  typedef struct packed {
    kind_t                   kind;
    logic [CHAR_W-1:0]       chr;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    rd_ok;
  } item_t;

  // Screen size in use after the zero and upper-bound corrections.
  typedef struct packed {
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
  } cfg_eff_t;

endpackage

// ===== rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front: input side of the text console character writer
// Accepts input transactions while the queue has room and classifies each
// one into a read, a control code or a printable put.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::ROW_W-1:0]     in_read_row,
  input  logic [tcw_pkg::COL_W-1:0]     in_read_col,
  input  tcw_pkg::cfg_eff_t             cfg_eff_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output tcw_pkg::item_t                item_o
);

  tcw_pkg::kind_t kind;

  assign in_stall = q_full_i;
  assign push_o   = in_valid && !q_full_i;

  always_comb begin
    if (in_operation) begin
      kind = tcw_pkg::K_READ;
    end else begin
      unique case (in_char_code)
        tcw_pkg::CODE_BS: kind = tcw_pkg::K_BS;
        tcw_pkg::CODE_LF: kind = tcw_pkg::K_LF;
        tcw_pkg::CODE_CR: kind = tcw_pkg::K_CR;
        default:          kind = tcw_pkg::K_PUT;
      endcase
    end
  end

  // A read outside the size in use answers with a blank.
  assign item_o.kind  = kind;
  assign item_o.chr   = in_char_code;
  assign item_o.row   = in_read_row;
  assign item_o.col   = in_read_col;
  assign item_o.rd_ok = (in_read_row < cfg_eff_i.rows) && (in_read_col < cfg_eff_i.cols);

endmodule

// ===== rtl/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_queue: short queue between the front and the back of the writer
// Holds classified transactions so that input and execution stall apart.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  tcw_pkg::item_t  push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tcw_pkg::item_t  pop_item_o
);

  localparam int PTR_W = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

  tcw_pkg::item_t     entry_r [tcw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign full_o     = (count_r == CNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_r != '0);
  assign pop_item_o = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        entry_r[wr_ptr_r] <= push_item_i;
        wr_ptr_r          <= ptr_inc(wr_ptr_r);
      end
      if (pop_i) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o || pop_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule

// ===== rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back: execution side of the text console character writer
// Owns the screen memory, the cursor, the ring row base, the per-row fill
// counts and the result register; runs each transaction via S_EXEC, S_DONE.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]        cfg_wdata,
  output tcw_pkg::cfg_eff_t                cfg_eff_o,
  input  logic                             q_valid_i,
  input  tcw_pkg::item_t                   q_item_i,
  output logic                             q_pop_o,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tcw_pkg::CHAR_W-1:0]       out_cell_char,
  output logic [tcw_pkg::COL_W-1:0]        out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]        out_cursor_row,
  output logic                             out_scrolled
);

  localparam int COL_W     = tcw_pkg::COL_W;
  localparam int ROW_W     = tcw_pkg::ROW_W;
  localparam int COL_W1    = COL_W + 1;
  localparam int ROW_W1    = ROW_W + 1;
  localparam int ROW_IDX_W = $clog2(MAX_ROWS);
  localparam int CELLS     = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = $clog2(CELLS);

  typedef enum logic [1:0] {
    S_WAIT,
    S_EXEC,
    S_DONE
  } state_t;

  function automatic logic [COL_W-1:0] sat_cols(input logic [COL_W-1:0] v);
    if (v == '0) begin
      return COL_W'(1);
    end
    if ({1'b0, v} > COL_W1'(MAX_COLS)) begin
      return COL_W'(MAX_COLS);
    end
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] sat_rows(input logic [ROW_W-1:0] v);
    if (v == '0) begin
      return ROW_W'(1);
    end
    if ({1'b0, v} > ROW_W1'(MAX_ROWS)) begin
      return ROW_W'(MAX_ROWS);
    end
    return v;
  endfunction

  state_t                       state_r;
  tcw_pkg::item_t               item_r;
  logic [COL_W-1:0]             cols_eff_r;
  logic [ROW_W-1:0]             rows_eff_r;
  logic [COL_W-1:0]             cur_col_r;
  logic [ROW_W-1:0]             cur_row_r;
  logic [ROW_W-1:0]             base_r;
  logic [COL_W-1:0]             hwm_r [MAX_ROWS];
  logic                         scroll_r;
  logic                         hit_r;
  logic [tcw_pkg::CHAR_W-1:0]   mem [CELLS];
  logic [tcw_pkg::CHAR_W-1:0]   mem_q_r;
  logic                         out_valid_r;
  logic [tcw_pkg::CHAR_W-1:0]   out_cell_r;
  logic [COL_W-1:0]             out_col_r;
  logic [ROW_W-1:0]             out_row_r;
  logic                         out_scrolled_r;

  logic                         out_free;
  logic                         is_read;
  logic                         cfg_hit;
  logic [ROW_W-1:0]             lrow;
  logic [ROW_W:0]               row_sum;
  logic [ROW_W-1:0]             phys;
  logic [ROW_IDX_W-1:0]         phys_idx;
  logic [ROW_IDX_W-1:0]         base_idx;
  logic [COL_W-1:0]             hwm_cur;
  logic [COL_W-1:0]             col_sel;
  logic [ADDR_W-1:0]            mem_addr;
  logic                         mem_we;
  logic                         mem_re;
  logic [COL_W:0]               col_inc;
  logic                         wrap;
  logic                         newline;
  logic                         last_row;
  logic                         scroll;
  logic                         wr_extend;
  logic                         rd_hit;
  logic [ROW_W:0]               base_inc;
  logic [COL_W-1:0]             col_nxt;
  logic [ROW_W-1:0]             row_nxt;
  logic [ROW_W-1:0]             base_nxt;

  assign cfg_eff_o.cols = cols_eff_r;
  assign cfg_eff_o.rows = rows_eff_r;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop_o  = q_valid_i && ((state_r == S_WAIT) || ((state_r == S_DONE) && out_free));
  assign cfg_hit  = cfg_wr_en && ((cfg_index == tcw_pkg::REG_COLS) ||
                                  (cfg_index == tcw_pkg::REG_ROWS));

  // Logical row to physical row through the ring base.
  assign is_read  = (item_r.kind == tcw_pkg::K_READ);
  assign lrow     = is_read ? item_r.row : cur_row_r;
  assign row_sum  = {1'b0, base_r} + {1'b0, lrow};
  assign phys     = (row_sum >= {1'b0, rows_eff_r}) ? ROW_W'(row_sum - {1'b0, rows_eff_r})
                                                    : row_sum[ROW_W-1:0];
  assign phys_idx = phys[ROW_IDX_W-1:0];
  assign base_idx = base_r[ROW_IDX_W-1:0];
  assign hwm_cur  = hwm_r[phys_idx];
  assign col_sel  = is_read ? item_r.col : cur_col_r;
  assign mem_addr = ADDR_W'(ADDR_W'(phys_idx) * ADDR_W'(MAX_COLS)) + ADDR_W'(col_sel);

  assign mem_we    = (state_r == S_EXEC) && (item_r.kind == tcw_pkg::K_PUT);
  assign rd_hit    = is_read && item_r.rd_ok && (item_r.col < hwm_cur);
  assign mem_re    = (state_r == S_EXEC) && rd_hit;
  assign wr_extend = (item_r.kind == tcw_pkg::K_PUT) && (cur_col_r == hwm_cur);

  assign col_inc  = {1'b0, cur_col_r} + COL_W1'(1);
  assign wrap     = (col_inc >= {1'b0, cols_eff_r});
  assign newline  = (item_r.kind == tcw_pkg::K_LF) ||
                    ((item_r.kind == tcw_pkg::K_PUT) && wrap);
  assign last_row = (cur_row_r == rows_eff_r - ROW_W'(1));
  assign scroll   = newline && last_row;
  assign base_inc = {1'b0, base_r} + ROW_W1'(1);

  always_comb begin
    col_nxt = cur_col_r;
    unique case (item_r.kind)
      tcw_pkg::K_READ: col_nxt = cur_col_r;
      tcw_pkg::K_BS:   col_nxt = (cur_col_r != '0) ? cur_col_r - COL_W'(1) : cur_col_r;
      tcw_pkg::K_LF,
      tcw_pkg::K_CR:   col_nxt = '0;
      tcw_pkg::K_PUT:  col_nxt = wrap ? '0 : col_inc[COL_W-1:0];
      default:         col_nxt = cur_col_r;
    endcase
  end

  assign row_nxt  = (newline && !last_row) ? cur_row_r + ROW_W'(1) : cur_row_r;
  assign base_nxt = !scroll ? base_r :
                    (base_inc == {1'b0, rows_eff_r}) ? '0 : base_inc[ROW_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= item_r.chr;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      out_valid_r <= 1'b0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      base_r      <= '0;
      scroll_r    <= 1'b0;
      hit_r       <= 1'b0;
      cols_eff_r  <= sat_cols(tcw_pkg::CFG_COLS_RESET);
      rows_eff_r  <= sat_rows(tcw_pkg::CFG_ROWS_RESET);
      for (int i = 0; i < MAX_ROWS; i++) begin
        hwm_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_WAIT: begin
          if (q_valid_i) begin
            item_r  <= q_item_i;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          cur_col_r <= col_nxt;
          cur_row_r <= row_nxt;
          base_r    <= base_nxt;
          scroll_r  <= scroll;
          hit_r     <= rd_hit;
          if (wr_extend) begin
            hwm_r[phys_idx] <= col_inc[COL_W-1:0];
          end
          if (scroll) begin
            hwm_r[base_idx] <= '0;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_cell_r     <= hit_r ? mem_q_r : tcw_pkg::BLANK;
            out_col_r      <= cur_col_r;
            out_row_r      <= cur_row_r;
            out_scrolled_r <= scroll_r;
            if (q_valid_i) begin
              item_r  <= q_item_i;
              state_r <= S_EXEC;
            end else begin
              state_r <= S_WAIT;
            end
          end
        end
        default: state_r <= S_WAIT;
      endcase
      if (cfg_hit) begin
        if (cfg_index == tcw_pkg::REG_COLS) begin
          cols_eff_r <= sat_cols(cfg_wdata);
        end else begin
          rows_eff_r <= sat_rows(cfg_wdata[ROW_W-1:0]);
        end
        cur_col_r <= '0;
        cur_row_r <= '0;
        base_r    <= '0;
        for (int i = 0; i < MAX_ROWS; i++) begin
          hwm_r[i] <= '0;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_cell_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_scrolled   = out_scrolled_r;

  a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r < cols_eff_r) && (cur_row_r < rows_eff_r))
    else $error("cursor outside the screen in use");

  a_base_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    base_r < rows_eff_r)
    else $error("ring row base outside the screen in use");

  a_scroll_lands_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scrolled_r) |->
      (out_row_r == rows_eff_r - ROW_W'(1)) && (out_col_r == '0))
    else $error("scroll result does not leave the cursor at the bottom row start");

endmodule

// ===== rtl/text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer: teletype-style text console with scroll
// Puts bytes on a character screen with backspace, newline, carriage return,
// line wrap and scroll, and reads back single screen cells.
// ----------------------------------------------------------------------------
// Each transaction passes through an execute state and a done state in the
// execution unit. In the execute state the single screen memory port is
// written or read and the cursor, ring row base and row fill counts are
// updated; in the done state the registered memory data is loaded into the
// result register, waiting while the held result is stalled, and the next
// queued transaction is taken as the result is loaded. A scroll costs
// nothing extra: rows live in a ring addressed through a base register, and
// the new bottom row is blanked by zeroing its fill count. Likewise a write
// of either configuration register clears the screen at once, so there is no
// clearing pass after reset or configuration. Configuration writes are only
// to be issued while no transaction is outstanding.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [tcw_pkg::CHAR_W-1:0]       in_char_code,
  input  logic [tcw_pkg::ROW_W-1:0]        in_read_row,
  input  logic [tcw_pkg::COL_W-1:0]        in_read_col,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tcw_pkg::CHAR_W-1:0]       out_cell_char,
  output logic [tcw_pkg::COL_W-1:0]        out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]        out_cursor_row,
  output logic                             out_scrolled,
  // Configuration write port
  input  logic                             cfg_wr_en,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcw_pkg::CFG_W-1:0]        cfg_wdata
);

  tcw_pkg::cfg_eff_t  cfg_eff;
  tcw_pkg::item_t     push_item;
  tcw_pkg::item_t     pop_item;
  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;

  // The front classifies each input transaction and takes the read range
  // check off the execution path.
  tcw_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .cfg_eff_i    (cfg_eff),
    .q_full_i     (q_full),
    .push_o       (push),
    .item_o       (push_item)
  );

  // The queue lets the input keep accepting while a result is stalled, until it fills.
  tcw_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  // The back end owns the screen store, the cursor and the result register.
  tcw_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cfg_eff_o      (cfg_eff),
    .q_valid_i      (q_valid),
    .q_item_i       (pop_item),
    .q_pop_o        (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_char  (out_cell_char),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_scrolled   (out_scrolled)
  );

endmodule
